// ===== rtl/core/ealu_pkg.sv =====
// Shared operation codes and inter-stage payload types for the 8-bit ALU.
package ealu_pkg;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADC   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SBC   = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_XOR   = 5'd5;
  localparam logic [4:0] OP_OR    = 5'd6;
  localparam logic [4:0] OP_CP    = 5'd7;
  localparam logic [4:0] OP_INC8  = 5'd8;
  localparam logic [4:0] OP_DEC8  = 5'd9;
  localparam logic [4:0] OP_INC16 = 5'd10;
  localparam logic [4:0] OP_DEC16 = 5'd11;
  localparam logic [4:0] OP_ADDHL = 5'd12;
  localparam logic [4:0] OP_RLC   = 5'd13;
  localparam logic [4:0] OP_RRC   = 5'd14;
  localparam logic [4:0] OP_RL    = 5'd15;
  localparam logic [4:0] OP_RR    = 5'd16;
  localparam logic [4:0] OP_SLA   = 5'd17;
  localparam logic [4:0] OP_SRA   = 5'd18;
  localparam logic [4:0] OP_SRL   = 5'd19;
  localparam logic [4:0] OP_SWAP  = 5'd20;

  // flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // decode stage -> execute stage
  typedef struct packed {
    logic [4:0]  func;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [3:0]  fin;
    logic [7:0]  bx;
    logic [7:0]  by;
    logic        bc;
    logic [15:0] wx;
    logic [15:0] wy;
    logic        wc;
  } ealu_dec_t;

  // execute stage -> flag stage
  typedef struct packed {
    logic [4:0]  func;
    logic [7:0]  a;
    logic [3:0]  fin;
    logic [8:0]  bsum;
    logic        bhalf;
    logic [16:0] wsum;
    logic        whalf;
    logic [7:0]  sres;
    logic        scarry;
  } ealu_exe_t;

endpackage

// ===== rtl/core/ealu_decode.sv =====
// Stage 1: selects adder operands and carry in for each operation.
module ealu_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         func,
  input  logic [7:0]         accumulator,
  input  logic [7:0]         operand,
  input  logic [3:0]         flags_in,
  input  logic [15:0]        hl_value,
  input  logic [15:0]        pair_value,
  output logic               dec_valid,
  input  logic               dec_ready,
  output ealu_pkg::ealu_dec_t dec
);
  import ealu_pkg::*;

  ealu_dec_t dec_next;
  logic      cin;

  assign cin      = flags_in[FLAG_C];
  assign in_ready = !dec_valid || dec_ready;

  always_comb begin
    dec_next      = '0;
    dec_next.func = func;
    dec_next.a    = accumulator;
    dec_next.b    = operand;
    dec_next.fin  = flags_in;
    dec_next.bx   = accumulator;
    dec_next.by   = operand;
    dec_next.bc   = 1'b0;
    dec_next.wx   = pair_value;
    dec_next.wy   = 16'h0000;
    dec_next.wc   = 1'b0;
    unique case (func) inside
      OP_ADC: dec_next.bc = cin;
      OP_SUB, OP_CP: begin
        dec_next.by = ~operand;
        dec_next.bc = 1'b1;
      end
      OP_SBC: begin
        dec_next.by = ~operand;
        dec_next.bc = ~cin;
      end
      OP_INC8: begin
        dec_next.bx = operand;
        dec_next.by = 8'h00;
        dec_next.bc = 1'b1;
      end
      OP_DEC8: begin
        dec_next.bx = operand;
        dec_next.by = 8'hFF;
      end
      OP_INC16: dec_next.wc = 1'b1;
      OP_DEC16: dec_next.wy = 16'hFFFF;
      OP_ADDHL: begin
        dec_next.wx = hl_value;
        dec_next.wy = pair_value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (in_ready) begin
      dec_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      dec <= dec_next;
    end
  end

endmodule

// ===== rtl/core/ealu_exec.sv =====
// Stage 2: byte and word adders, logic operations, rotates, shifts and swap.
module ealu_exec (
  input  logic                clk,
  input  logic                rst,
  input  logic                dec_valid,
  output logic                dec_ready,
  input  ealu_pkg::ealu_dec_t dec,
  output logic                exe_valid,
  input  logic                exe_ready,
  output ealu_pkg::ealu_exe_t exe
);
  import ealu_pkg::*;

  ealu_exe_t   exe_next;
  logic [4:0]  nib;
  logic [12:0] w12;
  logic        cin;

  assign dec_ready = !exe_valid || exe_ready;
  assign cin       = dec.fin[FLAG_C];

  always_comb begin
    nib = {1'b0, dec.bx[3:0]} + {1'b0, dec.by[3:0]} + {4'b0, dec.bc};
    w12 = {1'b0, dec.wx[11:0]} + {1'b0, dec.wy[11:0]} + {12'b0, dec.wc};

    exe_next        = '0;
    exe_next.func   = dec.func;
    exe_next.a      = dec.a;
    exe_next.fin    = dec.fin;
    exe_next.bsum   = {1'b0, dec.bx} + {1'b0, dec.by} + {8'b0, dec.bc};
    exe_next.bhalf  = nib[4];
    exe_next.wsum   = {1'b0, dec.wx} + {1'b0, dec.wy} + {16'b0, dec.wc};
    exe_next.whalf  = w12[12];
    exe_next.sres   = 8'h00;
    exe_next.scarry = 1'b0;
    unique case (dec.func)
      OP_AND: exe_next.sres = dec.a & dec.b;
      OP_XOR: exe_next.sres = dec.a ^ dec.b;
      OP_OR:  exe_next.sres = dec.a | dec.b;
      OP_RLC: begin
        exe_next.sres   = {dec.b[6:0], dec.b[7]};
        exe_next.scarry = dec.b[7];
      end
      OP_RRC: begin
        exe_next.sres   = {dec.b[0], dec.b[7:1]};
        exe_next.scarry = dec.b[0];
      end
      OP_RL: begin
        exe_next.sres   = {dec.b[6:0], cin};
        exe_next.scarry = dec.b[7];
      end
      OP_RR: begin
        exe_next.sres   = {cin, dec.b[7:1]};
        exe_next.scarry = dec.b[0];
      end
      OP_SLA: begin
        exe_next.sres   = {dec.b[6:0], 1'b0};
        exe_next.scarry = dec.b[7];
      end
      OP_SRA: begin
        exe_next.sres   = {dec.b[7], dec.b[7:1]};
        exe_next.scarry = dec.b[0];
      end
      OP_SRL: begin
        exe_next.sres   = {1'b0, dec.b[7:1]};
        exe_next.scarry = dec.b[0];
      end
      OP_SWAP: exe_next.sres = {dec.b[3:0], dec.b[7:4]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exe_valid <= 1'b0;
    end else if (dec_ready) begin
      exe_valid <= dec_valid;
    end
    if (dec_ready && dec_valid) begin
      exe <= exe_next;
    end
  end

endmodule

// ===== rtl/core/ealu_flags.sv =====
// Stage 3: result selection, zero detect and flag assembly; output register.
module ealu_flags (
  input  logic                clk,
  input  logic                rst,
  input  logic                exe_valid,
  output logic                exe_ready,
  input  ealu_pkg::ealu_exe_t exe,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          result_byte,
  output logic [15:0]         result_word,
  output logic [3:0]          flags_out
);
  import ealu_pkg::*;

  logic [7:0]  rb_next;
  logic [15:0] rw_next;
  logic [3:0]  f_next;
  logic        zsum;
  logic        zsres;

  assign exe_ready = !out_valid || out_ready;
  assign zsum      = (exe.bsum[7:0] == 8'h00);
  assign zsres     = (exe.sres == 8'h00);

  always_comb begin
    rb_next = 8'h00;
    rw_next = 16'h0000;
    f_next  = exe.fin;
    unique case (exe.func) inside
      OP_ADD, OP_ADC: begin
        rb_next = exe.bsum[7:0];
        f_next  = {zsum, 1'b0, exe.bhalf, exe.bsum[8]};
      end
      OP_SUB, OP_SBC: begin
        rb_next = exe.bsum[7:0];
        f_next  = {zsum, 1'b1, ~exe.bhalf, ~exe.bsum[8]};
      end
      OP_CP: begin
        rb_next = exe.a;
        f_next  = {zsum, 1'b1, ~exe.bhalf, ~exe.bsum[8]};
      end
      OP_AND: begin
        rb_next = exe.sres;
        f_next  = {zsres, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR, OP_OR: begin
        rb_next = exe.sres;
        f_next  = {zsres, 3'b000};
      end
      OP_INC8: begin
        rb_next = exe.bsum[7:0];
        f_next  = {zsum, 1'b0, exe.bhalf, exe.fin[FLAG_C]};
      end
      OP_DEC8: begin
        rb_next = exe.bsum[7:0];
        f_next  = {zsum, 1'b1, ~exe.bhalf, exe.fin[FLAG_C]};
      end
      OP_INC16, OP_DEC16: rw_next = exe.wsum[15:0];
      OP_ADDHL: begin
        rw_next = exe.wsum[15:0];
        f_next  = {exe.fin[FLAG_Z], 1'b0, exe.whalf, exe.wsum[16]};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL, OP_SWAP: begin
        rb_next = exe.sres;
        f_next  = {zsres, 2'b00, exe.scarry};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exe_ready) begin
      out_valid <= exe_valid;
    end
    if (exe_ready && exe_valid) begin
      result_byte <= rb_next;
      result_word <= rw_next;
      flags_out   <= f_next;
    end
  end

endmodule

// ===== rtl/core/eight_bit_alu_with_flags_unit.sv =====
// Top level of the 8-bit ALU with Z, N, H and C flags.
// Three register stages: operand and carry-in setup, the byte and word adders
// with the logic, rotate and shift unit, then result selection and flag
// assembly into the output register. A request is taken every cycle unless all
// stages are full and the output is stalled; an output stall holds every stage
// back to the first empty one, and the input stays ready as long as some stage has room.
module eight_bit_alu_with_flags_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  func,
  input  logic [7:0]  accumulator,
  input  logic [7:0]  operand,
  input  logic [3:0]  flags_in,
  input  logic [15:0] hl_value,
  input  logic [15:0] pair_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  result_byte,
  output logic [15:0] result_word,
  output logic [3:0]  flags_out
);
  import ealu_pkg::*;

  ealu_dec_t dec;
  ealu_exe_t exe;
  logic      dec_valid;
  logic      dec_ready;
  logic      exe_valid;
  logic      exe_ready;

  ealu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .accumulator (accumulator),
    .operand     (operand),
    .flags_in    (flags_in),
    .hl_value    (hl_value),
    .pair_value  (pair_value),
    .dec_valid   (dec_valid),
    .dec_ready   (dec_ready),
    .dec         (dec)
  );

  ealu_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec),
    .exe_valid (exe_valid),
    .exe_ready (exe_ready),
    .exe       (exe)
  );

  ealu_flags u_flags (
    .clk         (clk),
    .rst         (rst),
    .exe_valid   (exe_valid),
    .exe_ready   (exe_ready),
    .exe         (exe),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_byte (result_byte),
    .result_word (result_word),
    .flags_out   (flags_out)
  );

endmodule

// ===== rtl/core/ealu_checker.sv =====
// Port-level assertions for the 8-bit ALU, bound to the top level.
module ealu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [4:0]  func,
  input logic [7:0]  accumulator,
  input logic [7:0]  operand,
  input logic [3:0]  flags_in,
  input logic [15:0] hl_value,
  input logic [15:0] pair_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  result_byte,
  input logic [15:0] result_word,
  input logic [3:0]  flags_out
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({result_byte, result_word, flags_out}))
    else $error("stalled result changed");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // an empty output stage keeps the input ready
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input not ready with empty output stage");

  // a taken request reaches the output register when the output is not stalled
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready) |=> out_valid)
    else $error("request did not arrive after three cycles");

endmodule

bind eight_bit_alu_with_flags_unit ealu_checker u_ealu_checker (.*);
